/* src/cps_pkg.sv */
// Shared constants, types and codes of the class prediction smoother.
`timescale 1ns / 1ps
`default_nettype none

package cps_pkg;

    // Geometry
    localparam int WINDOW_DEPTH = 4;
    localparam int NUM_CLASSES  = 8;

    // Field widths
    localparam int LABEL_W      = 3;
    localparam int PROB_W       = 8;
    localparam int MIN_REP_W    = 3;
    localparam int THR_W        = 8;
    localparam int MIN_REPS_W   = 24;
    localparam int THRESHOLDS_W = 64;
    localparam int TDATA_W      = 16;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 64;

    // Derived widths
    localparam int FILL_W    = $clog2(WINDOW_DEPTH + 1);
    localparam int IDX_W     = $clog2(WINDOW_DEPTH);
    localparam int SUM_W     = PROB_W + $clog2(WINDOW_DEPTH);
    localparam int ALU_W     = SUM_W + 1;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);
    localparam int PAD_W     = TDATA_W - LABEL_W - PROB_W;

    // Register reset values
    localparam logic [LABEL_W-1:0]      IDLE_LABEL_RST    = 3'd0;
    localparam logic [LABEL_W-1:0]      UNKNOWN_LABEL_RST = 3'd1;
    localparam logic [MIN_REPS_W-1:0]   MIN_REPS_RST      = 24'd7190208;
    localparam logic [THRESHOLDS_W-1:0] THRESHOLDS_RST    = 64'hCDB3_B3B3_B3B3_0000;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IDLE_LABEL    = 2'd0,
        CFG_UNKNOWN_LABEL = 2'd1,
        CFG_MIN_REPEATS   = 2'd2,
        CFG_THRESHOLDS    = 2'd3
    } cfg_index_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ACCUM,
        ST_DIVIDE,
        ST_COMPARE,
        ST_FINISH
    } state_t;

    // Shared unit operations
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Configuration register set
    typedef struct packed {
        logic [LABEL_W-1:0]      idle_label;
        logic [LABEL_W-1:0]      unknown_label;
        logic [MIN_REPS_W-1:0]   min_reps;
        logic [THRESHOLDS_W-1:0] thresholds;
    } cfg_t;

    // Window update controls
    typedef struct packed {
        logic               clear;
        logic               append;
        logic               set_run;
        logic [LABEL_W-1:0] run_label;
        logic [PROB_W-1:0]  prob;
    } win_ctrl_t;

endpackage

`default_nettype wire

/* src/cps_window.sv */
// Probability window shift line with fill count and current run label.
`timescale 1ns / 1ps
`default_nettype none

module cps_window (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cps_pkg::win_ctrl_t        ctrl,
    input  wire logic [cps_pkg::IDX_W-1:0] rd_idx,
    output logic [cps_pkg::FILL_W-1:0]     fill,
    output logic [cps_pkg::LABEL_W-1:0]    run_label,
    output logic [cps_pkg::PROB_W-1:0]     rd_data
);
    import cps_pkg::*;

    logic [PROB_W-1:0]  win_reg [WINDOW_DEPTH];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [LABEL_W-1:0] run_label_reg;
    logic [LABEL_W-1:0] run_label_next;

    // Shift in the newest probability; the oldest drops off the far end
    always_ff @(posedge aclk) begin
        if (ctrl.append) begin
            win_reg[0] <= ctrl.prob;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // Next fill count and run label
    always_comb begin
        fill_next      = fill_reg;
        run_label_next = run_label_reg;
        if (ctrl.clear) begin
            fill_next = '0;
        end else if (ctrl.append && (fill_reg != FILL_W'(WINDOW_DEPTH))) begin
            fill_next = fill_reg + FILL_W'(1);
        end
        if (ctrl.set_run) begin
            run_label_next = ctrl.run_label;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            run_label_reg <= '0;
        end else begin
            fill_reg      <= fill_next;
            run_label_reg <= run_label_next;
        end
    end

    assign fill      = fill_reg;
    assign run_label = run_label_reg;
    assign rd_data   = win_reg[rd_idx];

endmodule

`default_nettype wire

/* src/cps_alu.sv */
// Shared add/subtract unit with unsigned greater-or-equal flag.
`timescale 1ns / 1ps
`default_nettype none

module cps_alu (
    input  wire logic [cps_pkg::ALU_W-1:0] a,
    input  wire logic [cps_pkg::ALU_W-1:0] b,
    input  wire cps_pkg::alu_op_t          op,
    output logic [cps_pkg::ALU_W-1:0]      result,
    output logic                           ge
);
    import cps_pkg::*;

    logic [ALU_W:0] diff;

    // Subtract one bit wider so the borrow shows a < b
    assign diff = {1'b0, a} - {1'b0, b};
    assign ge   = ~diff[ALU_W];

    always_comb begin
        case (op)
            ALU_ADD: result = a + b;
            ALU_SUB: result = diff[ALU_W-1:0];
            default: result = '0;
        endcase
    end

endmodule

`default_nettype wire

/* src/cps_ctrl.sv */
// Sequencer: classifies items, sums the window, divides and compares via the shared unit.
`timescale 1ns / 1ps
`default_nettype none

module cps_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire cps_pkg::cfg_t               cfg,
    // input beat
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [cps_pkg::LABEL_W-1:0] s_label,
    input  wire logic [cps_pkg::PROB_W-1:0]  s_prob,
    // result beat
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [cps_pkg::LABEL_W-1:0]      m_label,
    output logic [cps_pkg::PROB_W-1:0]       m_prob,
    // window
    output cps_pkg::win_ctrl_t               win_ctrl,
    output logic [cps_pkg::IDX_W-1:0]        rd_idx,
    input  wire logic [cps_pkg::FILL_W-1:0]  fill,
    input  wire logic [cps_pkg::LABEL_W-1:0] run_label,
    input  wire logic [cps_pkg::PROB_W-1:0]  rd_data,
    // shared unit
    output logic [cps_pkg::ALU_W-1:0]        alu_a,
    output logic [cps_pkg::ALU_W-1:0]        alu_b,
    output cps_pkg::alu_op_t                 alu_op,
    input  wire logic [cps_pkg::ALU_W-1:0]   alu_result,
    input  wire logic                        alu_ge
);
    import cps_pkg::*;

    localparam int CMP_W = FILL_W + MIN_REP_W;

    state_t                 state_reg, state_next;
    logic [LABEL_W-1:0]     label_reg, label_next;
    logic [PROB_W-1:0]      prob_reg, prob_next;
    logic [FILL_W-1:0]      idx_reg, idx_next;
    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic [FILL_W-1:0]      rem_reg, rem_next;
    logic [DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [LABEL_W-1:0]     res_label_reg, res_label_next;
    logic [PROB_W-1:0]      res_prob_reg, res_prob_next;
    logic                   m_valid_reg, m_valid_next;
    logic [LABEL_W-1:0]     m_label_reg, m_label_next;
    logic [PROB_W-1:0]      m_prob_reg, m_prob_next;

    logic [MIN_REP_W-1:0]   min_rep;
    logic [THR_W-1:0]       thr;
    logic [FILL_W:0]        trial;
    logic                   is_pass;
    logic                   is_out_of_range;

    // Per-class settings of the latched label
    assign min_rep = cfg.min_reps[MIN_REP_W*label_reg +: MIN_REP_W];
    assign thr     = cfg.thresholds[THR_W*label_reg +: THR_W];

    // Restoring division: bring down the next dividend bit
    assign trial = {rem_reg, acc_reg[SUM_W-1]};

    assign is_pass         = (s_label == cfg.idle_label) || (s_label == cfg.unknown_label);
    assign is_out_of_range = ({1'b0, s_label} >= (LABEL_W+1)'(NUM_CLASSES));

    // Next state and datapath control
    always_comb begin
        state_next     = state_reg;
        label_next     = label_reg;
        prob_next      = prob_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        res_label_next = res_label_reg;
        res_prob_next  = res_prob_reg;
        m_valid_next   = m_valid_reg;
        m_label_next   = m_label_reg;
        m_prob_next    = m_prob_reg;

        win_ctrl           = '0;
        win_ctrl.run_label = s_label;
        win_ctrl.prob      = s_prob;
        rd_idx             = idx_reg[IDX_W-1:0];
        alu_a              = ALU_W'(acc_reg);
        alu_b              = '0;
        alu_op             = ALU_ADD;
        s_tready           = 1'b0;

        // Drop the result beat once taken
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    label_next       = s_label;
                    prob_next        = s_prob;
                    win_ctrl.set_run = 1'b1;
                    if (is_pass) begin
                        win_ctrl.clear = 1'b1;
                        res_label_next = s_label;
                        res_prob_next  = s_prob;
                        state_next     = ST_FINISH;
                    end else if (is_out_of_range) begin
                        win_ctrl.clear = 1'b1;
                        res_label_next = cfg.unknown_label;
                        res_prob_next  = s_prob;
                        state_next     = ST_FINISH;
                    end else if (run_label != s_label) begin
                        win_ctrl.clear = 1'b1;
                        state_next     = ST_CHECK;
                    end else begin
                        win_ctrl.append = 1'b1;
                        state_next      = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (CMP_W'(fill) < CMP_W'(min_rep)) begin
                    res_label_next = cfg.unknown_label;
                    res_prob_next  = prob_reg;
                    state_next     = ST_FINISH;
                end else begin
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                // Sum one window entry per cycle
                if (idx_reg == fill) begin
                    if (fill == '0) begin
                        state_next = ST_COMPARE;
                    end else begin
                        rem_next   = '0;
                        cnt_next   = DIV_CNT_W'(SUM_W);
                        state_next = ST_DIVIDE;
                    end
                end else begin
                    alu_a    = ALU_W'(acc_reg);
                    alu_b    = ALU_W'(rd_data);
                    alu_op   = ALU_ADD;
                    acc_next = alu_result[SUM_W-1:0];
                    idx_next = idx_reg + FILL_W'(1);
                end
            end
            ST_DIVIDE: begin
                // One quotient bit per cycle, shifted into the sum register
                alu_a    = ALU_W'(trial);
                alu_b    = ALU_W'(fill);
                alu_op   = ALU_SUB;
                acc_next = {acc_reg[SUM_W-2:0], alu_ge};
                rem_next = alu_ge ? alu_result[FILL_W-1:0] : trial[FILL_W-1:0];
                cnt_next = cnt_reg - DIV_CNT_W'(1);
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    state_next = ST_COMPARE;
                end
            end
            ST_COMPARE: begin
                alu_a  = ALU_W'(acc_reg);
                alu_b  = ALU_W'(thr);
                alu_op = ALU_SUB;
                if (alu_ge) begin
                    res_label_next = label_reg;
                    res_prob_next  = acc_reg[PROB_W-1:0];
                end else begin
                    res_label_next = cfg.unknown_label;
                    res_prob_next  = prob_reg;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // Hand the result to the output register when it is free
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_label_next = res_label_reg;
                    m_prob_next  = res_prob_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        label_reg     <= label_next;
        prob_reg      <= prob_next;
        idx_reg       <= idx_next;
        acc_reg       <= acc_next;
        rem_reg       <= rem_next;
        cnt_reg       <= cnt_next;
        res_label_reg <= res_label_next;
        res_prob_reg  <= res_prob_next;
        m_label_reg   <= m_label_next;
        m_prob_reg    <= m_prob_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_label  = m_label_reg;
    assign m_prob   = m_prob_reg;

endmodule

`default_nettype wire

/* src/class_prediction_smoother_top.sv */
// Top level of the class prediction smoother: ports, configuration registers, units.
// Path to m_tvalid: idle, unknown and out-of-range labels go straight to the handoff; a label
//   below the class minimum passes the check first; an empty window skips the divide; else
//   check, one sum per filled entry, 10 divide steps, compare, handoff.
// One item at a time, taken once the last is handed off; the add/subtract unit sets the pace.
// Reset: aresetn is synchronous, active low; it empties the window, clears the run label
//   and loads the registers with their defaults. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module class_prediction_smoother_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [cps_pkg::TDATA_W-1:0]     s_tdata,   // class_label, probability
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [cps_pkg::TDATA_W-1:0]          m_tdata,   // out_label, out_probability
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [cps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cps_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import cps_pkg::*;

    cfg_t               cfg_reg, cfg_next;
    win_ctrl_t          win_ctrl;
    logic [IDX_W-1:0]   rd_idx;
    logic [FILL_W-1:0]  fill;
    logic [LABEL_W-1:0] run_label;
    logic [PROB_W-1:0]  rd_data;
    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    alu_op_t            alu_op;
    logic [ALU_W-1:0]   alu_result;
    logic               alu_ge;
    logic [LABEL_W-1:0] m_label;
    logic [PROB_W-1:0]  m_prob;

    assign cfg_ready = 1'b1;

    // Decode a configuration beat
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_IDLE_LABEL:    cfg_next.idle_label    = cfg_data[LABEL_W-1:0];
                CFG_UNKNOWN_LABEL: cfg_next.unknown_label = cfg_data[LABEL_W-1:0];
                CFG_MIN_REPEATS:   cfg_next.min_reps      = cfg_data[MIN_REPS_W-1:0];
                CFG_THRESHOLDS:    cfg_next.thresholds    = cfg_data[THRESHOLDS_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.idle_label    <= IDLE_LABEL_RST;
            cfg_reg.unknown_label <= UNKNOWN_LABEL_RST;
            cfg_reg.min_reps      <= MIN_REPS_RST;
            cfg_reg.thresholds    <= THRESHOLDS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cps_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_label    (s_tdata[LABEL_W-1:0]),
        .s_prob     (s_tdata[LABEL_W +: PROB_W]),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_label    (m_label),
        .m_prob     (m_prob),
        .win_ctrl   (win_ctrl),
        .rd_idx     (rd_idx),
        .fill       (fill),
        .run_label  (run_label),
        .rd_data    (rd_data),
        .alu_a      (alu_a),
        .alu_b      (alu_b),
        .alu_op     (alu_op),
        .alu_result (alu_result),
        .alu_ge     (alu_ge)
    );

    cps_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (win_ctrl),
        .rd_idx    (rd_idx),
        .fill      (fill),
        .run_label (run_label),
        .rd_data   (rd_data)
    );

    cps_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .op     (alu_op),
        .result (alu_result),
        .ge     (alu_ge)
    );

    // Pack the result beat, padding to whole bytes
    assign m_tdata = {{PAD_W{1'b0}}, m_prob, m_label};

endmodule

`default_nettype wire

/* src/cps_checker.sv */
// Port-level checks of the class prediction smoother, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module cps_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Reset empties the result register
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // One item at a time: input closes right after a beat is taken
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready while an item is in work");

    // Result padding stays zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:11] == 5'd0))
        else $error("result padding not zero");

endmodule

bind class_prediction_smoother_top cps_checker u_cps_checker (.*);

`default_nettype wire
